@@ src/whfm_pkg.sv @@
// whfm_pkg: shared widths, configuration register codes and reset values
// for the weighted histogram block. No dependencies.
package whfm_pkg;

  // Fixed field widths
  localparam int XW        = 32;  // sample, weight and range registers (Q16.16)
  localparam int NBW       = 9;   // num_bins register
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_X_MIN    = 2'd0;
  localparam cfg_idx_t CFG_X_MAX    = 2'd1;
  localparam cfg_idx_t CFG_INV_BW   = 2'd2;
  localparam cfg_idx_t CFG_NUM_BINS = 2'd3;

  // Register reset values
  localparam logic signed [XW-1:0] X_MIN_RST    = 32'sd0;
  localparam logic signed [XW-1:0] X_MAX_RST    = 32'sd65536;
  localparam logic        [XW-1:0] INV_BW_RST   = 32'd16777216;
  localparam logic        [NBW-1:0] NUM_BINS_RST = 9'd256;

endpackage

@@ src/whfm_ram.sv @@
// whfm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module whfm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 258
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/weighted_histogram_fill_max_top.sv @@
// weighted_histogram_fill_max_top: weighted 1-D histogram with saturating bins
// and a largest-bin query. Depends on whfm_pkg and whfm_ram.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------------
//   input    | start & !busy        | in_mode, in_sample_x, in_weight
//   result   | out_valid (1 cycle)  | out_bin_index, out_out_of_range,
//            |                      | out_saturated, out_max_count
//   config   | cfg_valid & cfg_ready| cfg_index, cfg_wdata
//
// A fill keeps busy high through range check and multiply, bin select and
// read, add and write back; its result strobes in the cycle after, when the
// next item can already be taken, so a new fill waits for the last to finish.
// A max query reads one regular bin per cycle through the RAM read port, bins
// 1 to the clamped num_bins, and stays busy until the largest count is sent.
// After reset the bin RAM is cleared one entry per cycle, all BINS + 2 entries,
// with busy high throughout. Config writes are taken in any cycle (cfg_ready
// is tied high). Results cannot be stalled by the receiver.
module weighted_histogram_fill_max_top #(
  parameter int BINS        = 256,
  parameter int COUNT_WIDTH = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_mode,
  input  logic signed [whfm_pkg::XW-1:0]     in_sample_x,
  input  logic signed [whfm_pkg::XW-1:0]     in_weight,
  // result channel
  output logic                               out_valid,
  output logic [$clog2(BINS+2)-1:0]          out_bin_index,
  output logic                               out_out_of_range,
  output logic                               out_saturated,
  output logic signed [COUNT_WIDTH-1:0]      out_max_count,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  whfm_pkg::cfg_idx_t                 cfg_index,
  input  logic [whfm_pkg::XW-1:0]            cfg_wdata
);

  import whfm_pkg::*;

  localparam int IDX_W = $clog2(BINS + 2);
  localparam int SUM_W = ((COUNT_WIDTH > XW) ? COUNT_WIDTH : XW) + 1;
  localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(BINS + 1);
  localparam logic signed [SUM_W-1:0] CNT_MAX_S =
    (SUM_W'(1) << (COUNT_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] CNT_MIN_S = -CNT_MAX_S - SUM_W'(1);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_MUL,
    S_IDX,
    S_RD,
    S_SCAN,
    S_SEND
  } state_t;

  // Configuration registers
  logic signed [XW-1:0]  x_min_r;
  logic signed [XW-1:0]  x_max_r;
  logic        [XW-1:0]  inv_bw_r;
  logic        [NBW-1:0] num_bins_r;

  // Sequencer and datapath registers
  state_t                        state_r;
  logic [IDX_W-1:0]              clr_idx_r;
  logic [IDX_W-1:0]              scan_idx_r;
  logic                          pend_r;
  logic signed [XW-1:0]          x_r;
  logic signed [XW-1:0]          w_r;
  logic                          oor_r;
  logic [2*XW-1:0]               prod_r;
  logic [IDX_W-1:0]              bin_r;
  logic signed [COUNT_WIDTH-1:0] best_r;

  // Result registers
  logic                          out_valid_r;
  logic [IDX_W-1:0]              out_bin_index_r;
  logic                          out_oor_r;
  logic                          out_sat_r;
  logic signed [COUNT_WIDTH-1:0] out_max_count_r;

  // RAM port signals
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  // Combinational helpers
  logic [IDX_W-1:0]              used_bins;
  logic                          oor_nxt;
  logic [XW-1:0]                 diff;
  logic [IDX_W-1:0]              bin_nxt;
  logic signed [SUM_W-1:0]       sum;
  logic                          sat_hi;
  logic                          sat_lo;
  logic [COUNT_WIDTH-1:0]        cnt_nxt;
  logic signed [COUNT_WIDTH-1:0] rd_cnt;
  logic                          accept;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r    <= X_MIN_RST;
      x_max_r    <= X_MAX_RST;
      inv_bw_r   <= INV_BW_RST;
      num_bins_r <= NUM_BINS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_X_MIN:    x_min_r    <= cfg_wdata;
        CFG_X_MAX:    x_max_r    <= cfg_wdata;
        CFG_INV_BW:   inv_bw_r   <= cfg_wdata;
        CFG_NUM_BINS: num_bins_r <= cfg_wdata[NBW-1:0];
      endcase
    end
  end

  // Bins in use: zero reads as one, above BINS reads as BINS
  always_comb begin
    if (num_bins_r == '0) begin
      used_bins = IDX_W'(1);
    end else if (32'(num_bins_r) > 32'(BINS)) begin
      used_bins = IDX_W'(BINS);
    end else begin
      used_bins = IDX_W'(num_bins_r);
    end
  end

  // Range check and offset from the lower edge
  assign oor_nxt = (x_r < x_min_r) || (x_r > x_max_r);
  assign diff    = XW'(x_r - x_min_r);

  // Bin select: bin 0 when out of range, else integer part of the product plus one, clipped to used_bins + 1
  always_comb begin
    if (oor_r) begin
      bin_nxt = '0;
    end else if (prod_r[2*XW-1:XW] >= XW'(used_bins)) begin
      bin_nxt = used_bins + IDX_W'(1);
    end else begin
      bin_nxt = IDX_W'(prod_r[2*XW-1:XW]) + IDX_W'(1);
    end
  end

  // Saturating accumulate
  assign rd_cnt = $signed(ram_rdata);
  assign sum    = SUM_W'(rd_cnt) + SUM_W'(w_r);
  assign sat_hi = (sum > CNT_MAX_S);
  assign sat_lo = (sum < CNT_MIN_S);
  always_comb begin
    if (sat_hi) begin
      cnt_nxt = CNT_MAX_S[COUNT_WIDTH-1:0];
    end else if (sat_lo) begin
      cnt_nxt = CNT_MIN_S[COUNT_WIDTH-1:0];
    end else begin
      cnt_nxt = sum[COUNT_WIDTH-1:0];
    end
  end

  // RAM port muxing
  assign ram_we    = (state_r == S_CLR) || (state_r == S_RD);
  assign ram_waddr = (state_r == S_CLR) ? clr_idx_r : bin_r;
  assign ram_wdata = (state_r == S_CLR) ? '0 : cnt_nxt;
  assign ram_raddr = (state_r == S_IDX) ? bin_nxt : scan_idx_r;

  whfm_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (BINS + 2)
  ) u_bin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer, datapath and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      scan_idx_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        // sweep zeros through the bin RAM
        S_CLR: begin
          clr_idx_r <= clr_idx_r + IDX_W'(1);
          if (clr_idx_r == LAST_BIN) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            x_r <= in_sample_x;
            w_r <= in_weight;
            if (in_mode) begin
              scan_idx_r <= IDX_W'(1);
              pend_r     <= 1'b0;
              best_r     <= '0;
              state_r    <= S_SCAN;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          oor_r   <= oor_nxt;
          prod_r  <= (2*XW)'(diff) * (2*XW)'(inv_bw_r);
          state_r <= S_IDX;
        end
        // bin read issued here
        S_IDX: begin
          bin_r   <= bin_nxt;
          state_r <= S_RD;
        end
        // read data back: write updated count, send result
        S_RD: begin
          out_valid_r     <= 1'b1;
          out_bin_index_r <= bin_r;
          out_oor_r       <= oor_r;
          out_sat_r       <= sat_hi || sat_lo;
          out_max_count_r <= '0;
          state_r         <= S_IDLE;
        end
        // one bin read per cycle, compare the previous read
        S_SCAN: begin
          pend_r <= 1'b1;
          if (pend_r && (rd_cnt > best_r)) begin
            best_r <= rd_cnt;
          end
          if (scan_idx_r == used_bins) begin
            state_r <= S_SEND;
          end else begin
            scan_idx_r <= scan_idx_r + IDX_W'(1);
          end
        end
        // last bin's data arrives, send the maximum
        S_SEND: begin
          out_valid_r     <= 1'b1;
          out_bin_index_r <= '0;
          out_oor_r       <= 1'b0;
          out_sat_r       <= 1'b0;
          out_max_count_r <= (rd_cnt > best_r) ? rd_cnt : best_r;
          pend_r          <= 1'b0;
          state_r         <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bin_index    = out_bin_index_r;
  assign out_out_of_range = out_oor_r;
  assign out_saturated    = out_sat_r;
  assign out_max_count    = out_max_count_r;

endmodule

@@ src/whfm_checker.sv @@
// whfm_checker: port-level assertions for weighted_histogram_fill_max_top,
// attached by bind. No package dependency.
module whfm_checker #(
  parameter int BINS        = 256,
  parameter int COUNT_WIDTH = 48
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [$clog2(BINS+2)-1:0]     out_bin_index,
  input logic                          out_out_of_range,
  input logic                          out_saturated,
  input logic [COUNT_WIDTH-1:0]        out_max_count
);

  // A transfer in makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  // A result only ever follows a busy cycle and lasts one cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) ##1 !out_valid)
    else $error("result strobe without work or longer than one cycle");

  // The reported maximum is never negative
  a_max_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_max_count[COUNT_WIDTH-1])
    else $error("negative max count");

  // A nonzero maximum comes from a query: no fill fields alongside it
  a_max_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_max_count != '0) |->
      (out_bin_index == '0) && !out_out_of_range && !out_saturated)
    else $error("fill fields set on a max result");

  // Out-of-range samples always land in the overflow bin
  a_oor_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> (out_bin_index == '0))
    else $error("out-of-range sample not in overflow bin");

endmodule

bind weighted_histogram_fill_max_top whfm_checker #(
  .BINS        (BINS),
  .COUNT_WIDTH (COUNT_WIDTH)
) u_whfm_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for weighted_histogram_fill_max_top. A scoreboard
// class predicts the bin store and checks every result. Depends on whfm_pkg and the RTL.

typedef enum bit {MODE_FILL = 1'b0, MODE_MAX = 1'b1} hist_mode_t;

// Bin-store predictor and queue of expected results
class hist_scoreboard;
  localparam int     BINS        = 256;
  localparam int     CW          = 48;
  localparam longint CNT_MAX     = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CNT_MIN     = -CNT_MAX - 1;
  localparam int     MAX_PRINTED = 30;

  typedef struct packed {
    logic [8:0]           bin_index;
    logic                 out_of_range;
    logic                 saturated;
    logic signed [CW-1:0] max_count;
  } hist_result_t;

  longint             bin_count [BINS+2];
  logic signed [31:0] x_min;
  logic signed [31:0] x_max;
  logic [31:0]        inv_bin_width;
  logic [8:0]         num_bins;
  hist_result_t       results_due [$];
  int                 errors;

  function new();
    foreach (bin_count[i]) bin_count[i] = 0;
    x_min         = whfm_pkg::X_MIN_RST;
    x_max         = whfm_pkg::X_MAX_RST;
    inv_bin_width = whfm_pkg::INV_BW_RST;
    num_bins      = whfm_pkg::NUM_BINS_RST;
    errors        = 0;
  endfunction

  function void set_reg(whfm_pkg::cfg_idx_t idx, logic [31:0] data);
    case (idx)
      whfm_pkg::CFG_X_MIN:    x_min = data;
      whfm_pkg::CFG_X_MAX:    x_max = data;
      whfm_pkg::CFG_INV_BW:   inv_bin_width = data;
      whfm_pkg::CFG_NUM_BINS: num_bins = data[8:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return results_due.size();
  endfunction

  // num_bins is clamped to 1..BINS
  function int active_bins();
    if (num_bins == 0) return 1;
    if (num_bins > BINS) return BINS;
    return int'(num_bins);
  endfunction

  // Accepted input transfer: update the store and queue the expected result
  function void note_input(hist_mode_t mode, logic signed [31:0] x, logic signed [31:0] w);
    hist_result_t         r;
    int                   n;
    int                   i;
    int                   b;
    longint               best;
    longint               diff;
    longint               sum;
    longint unsigned      prod;
    longint unsigned      slot;
    n = active_bins();
    r = '0;
    if (mode == MODE_MAX) begin
      // largest regular count, floor at zero
      best = 0;
      for (i = 1; i <= n; i++)
        if (bin_count[i] > best) best = bin_count[i];
      r.max_count = best[CW-1:0];
    end else begin
      if (x < x_min || x > x_max) begin
        b = 0;
        r.out_of_range = 1'b1;
      end else begin
        // exact Q32.32 product, keep the integer part, clip at n + 1
        diff = longint'(x) - longint'(x_min);
        prod = diff;
        prod = prod * {32'd0, inv_bin_width};
        slot = (prod >> 32) + 1;
        if (slot > n + 1) slot = n + 1;
        b = int'(slot);
      end
      // saturating add
      sum = bin_count[b] + longint'(w);
      if (sum > CNT_MAX) begin
        sum = CNT_MAX;
        r.saturated = 1'b1;
      end else if (sum < CNT_MIN) begin
        sum = CNT_MIN;
        r.saturated = 1'b1;
      end
      bin_count[b] = sum;
      r.bin_index = b[8:0];
    end
    results_due.push_back(r);
  endfunction

  task report(string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Accepted result transfer: compare with the oldest expectation
  task check_result(logic [8:0] bin, logic oor, logic sat, logic signed [CW-1:0] mc);
    hist_result_t want;
    if (results_due.size() == 0) begin
      report($sformatf("result with nothing expected (bin %0d, max %0d)", bin, mc));
      return;
    end
    want = results_due.pop_front();
    if (bin !== want.bin_index)
      report($sformatf("bin_index got %0d want %0d", bin, want.bin_index));
    if (oor !== want.out_of_range)
      report($sformatf("out_of_range got %b want %b", oor, want.out_of_range));
    if (sat !== want.saturated)
      report($sformatf("saturated got %b want %b", sat, want.saturated));
    if (mc !== want.max_count)
      report($sformatf("max_count got %0d want %0d", mc, want.max_count));
  endtask

  task flush_leftovers();
    while (results_due.size() != 0) begin
      report($sformatf("result never arrived (bin %0d)", results_due[0].bin_index));
      void'(results_due.pop_front());
    end
  endtask
endclass

module testbench;
  import whfm_pkg::*;

  localparam int                 BINS          = 256;
  localparam int                 COUNT_WIDTH   = 48;
  localparam int                 RANDOM_ITEMS  = 900;
  localparam int                 IDLE_PCT      = 28;
  localparam int                 MAX_PCT       = 8;
  localparam int                 BIG_FILLS     = 4;
  localparam int                 DRAIN_LIMIT   = 2000;
  localparam int                 TAIL_CYCLES   = 8;
  localparam int                 STEADY_PHASE  = 8;
  localparam longint             RUN_LIMIT_NS  = 25_000_000;
  localparam logic signed [31:0] S32_MIN       = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX       = 32'sh7FFF_FFFF;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          in_mode = 1'b0;
  logic signed [31:0]            in_sample_x = '0;
  logic signed [31:0]            in_weight = '0;
  logic                          out_valid;
  logic [$clog2(BINS+2)-1:0]     out_bin_index;
  logic                          out_out_of_range;
  logic                          out_saturated;
  logic signed [COUNT_WIDTH-1:0] out_max_count;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  cfg_idx_t                      cfg_index = CFG_X_MIN;
  logic [31:0]                   cfg_wdata = '0;

  hist_scoreboard sb;
  bit             gaps_on = 1'b1;

  weighted_histogram_fill_max_top #(
    .BINS        (BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_sample_x      (in_sample_x),
    .in_weight        (in_weight),
    .out_valid        (out_valid),
    .out_bin_index    (out_bin_index),
    .out_out_of_range (out_out_of_range),
    .out_saturated    (out_saturated),
    .out_max_count    (out_max_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 125 MHz clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // Transfer monitor: results are checked before the new input is queued
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result(out_bin_index, out_out_of_range, out_saturated, out_max_count);
      if (start && !busy)
        sb.note_input(hist_mode_t'(in_mode), in_sample_x, in_weight);
    end
  end

  // One input transfer; in about IDLE_PCT of the cycles in which the block
  // could take it, start is held low instead
  task automatic send_item(hist_mode_t mode, logic signed [31:0] x, logic signed [31:0] w);
    if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      // busy cycles do not count as idle ones
      do @(posedge clk); while (busy || $urandom_range(99) < IDLE_PCT);
    end
    start       <= 1'b1;
    in_mode     <= mode;
    in_sample_x <= x;
    in_weight   <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic write_config(logic signed [31:0] lo, logic signed [31:0] hi,
                              logic [31:0] inv, logic [8:0] nb);
    write_reg(CFG_X_MIN, lo);
    write_reg(CFG_X_MAX, hi);
    write_reg(CFG_INV_BW, inv);
    write_reg(CFG_NUM_BINS, {23'd0, nb});
    cfg_valid <= 1'b0;
  endtask

  // Stop sending and wait until every expected result is in
  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while ((busy || sb.pending() != 0) && waited < DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Samples: mostly inside the range, plus edges, just outside and anywhere
  function automatic logic signed [31:0] pick_sample(logic signed [31:0] lo,
                                                     logic signed [31:0] hi);
    longint      span;
    int unsigned sel;
    sel  = $urandom_range(99);
    span = longint'(hi) - longint'(lo);
    if (sel < 8) return lo;
    if (sel < 14) return hi;
    if (sel < 18) return lo - 1;
    if (sel < 22) return hi + 1;
    if (sel < 32 || span < 0) return $urandom;
    return lo + ({$urandom, $urandom} % (span + 1));
  endfunction

  function automatic logic signed [31:0] pick_weight();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 65) return $urandom_range(200) - 100;
    if (sel < 85) return $urandom;
    case (sel % 5)
      0:       return S32_MIN;
      1:       return S32_MAX;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  task automatic send_random(logic signed [31:0] lo, logic signed [31:0] hi);
    if ($urandom_range(99) < MAX_PCT)
      send_item(MODE_MAX, $urandom, $urandom);
    else
      send_item(MODE_FILL, pick_sample(lo, hi), pick_weight());
  endtask

  // Settings for one random phase; the early phases force the corner settings
  task automatic pick_phase(input int phase, output logic signed [31:0] lo,
                            output logic signed [31:0] hi, output logic [31:0] inv,
                            output logic [8:0] nb);
    longint span;
    longint fit_inv;
    lo   = $urandom;
    span = {$urandom, $urandom} >> $urandom_range(32, 63);
    if (phase == 0) begin
      lo   = S32_MIN;
      span = 64'hFFFF_FFFF;
    end
    if (phase == 6 && span == 0) span = 1;
    if (phase == 7) span = 0;
    hi = (longint'(lo) + span > longint'(S32_MAX)) ? S32_MAX : lo + span[31:0];
    // upper edge below lower edge
    if (phase == 6) {lo, hi} = {hi, lo};

    // few bins half of the time keeps max scans short
    nb = ($urandom_range(1) == 0) ? $urandom_range(1, 16) : $urandom_range(1, BINS);
    case (phase)
      1:       nb = 0;
      2:       nb = 9'h1FF;
      3:       nb = BINS + 1;
      7:       nb = 1;
      default: ;
    endcase

    // reciprocal that spreads the range over the bins, with some jitter
    span = longint'(hi) - longint'(lo);
    if (span < 0) begin
      inv = $urandom;
    end else begin
      fit_inv = (longint'(nb) << 32) / (span + 1);
      inv = (fit_inv > 64'sh0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : fit_inv[31:0];
      case ($urandom_range(9))
        0, 1:    inv = inv + $urandom_range(1, 64);
        2:       inv = $urandom;
        default: ;
      endcase
    end
    if (phase == 4) inv = 32'd0;
    if (phase == 5) inv = 32'hFFFF_FFFF;
  endtask

  // Main sequence
  initial begin
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [31:0]        inv;
    logic [8:0]         nb;
    int                 phase;
    int                 sent;
    int                 count;

    sb = new();

    // reset, then wait out the bin clearing pass
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    do @(posedge clk); while (busy);

    // directed part on the reset settings: 256 bins over [0.0, 1.0]
    send_item(MODE_MAX, 0, 0);                 // empty store
    send_item(MODE_FILL, 0, 1);                // lower edge
    send_item(MODE_FILL, 32'sd65535, 5);       // last regular bin
    send_item(MODE_FILL, X_MAX_RST, 3);        // upper edge lands in the clip slot
    send_item(MODE_FILL, -1, S32_MIN);         // just below the range
    send_item(MODE_FILL, 32'sd65537, S32_MAX); // just above the range
    send_item(MODE_FILL, S32_MIN, 0);
    send_item(MODE_FILL, S32_MAX, -1);
    send_item(MODE_FILL, 32'sd32768, S32_MAX); // middle bin
    send_item(MODE_FILL, 32'sd256, -7);        // exact bin boundary, negative count
    send_item(MODE_FILL, 32'sd255, 2);
    send_item(MODE_MAX, S32_MAX, S32_MIN);
    send_item(MODE_FILL, 32'sd32768, S32_MIN);
    send_item(MODE_MAX, $urandom, $urandom);
    drain();

    // random phases, each with its own settings
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      pick_phase(phase, lo, hi, inv, nb);
      write_config(lo, hi, inv, nb);
      gaps_on = (phase != STEADY_PHASE);
      count   = $urandom_range(40, 90);
      repeat (count) send_random(lo, hi);
      sent  += count;
      phase++;
      drain();
    end

    // large weights into bin 1 and the overflow bin, back to back
    gaps_on = 1'b0;
    write_config(X_MIN_RST, X_MAX_RST, INV_BW_RST, NUM_BINS_RST);
    repeat (BIG_FILLS) send_item(MODE_FILL, 0, S32_MAX);
    repeat (BIG_FILLS) send_item(MODE_FILL, -1, S32_MIN);
    send_item(MODE_MAX, 0, 0);
    send_item(MODE_FILL, 0, -1);
    send_item(MODE_FILL, -1, 1);
    send_item(MODE_MAX, 0, 0);
    gaps_on = 1'b1;
    drain();

    sb.flush_leftovers();
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

@@ weighted_histogram_fill_max_top.f @@
src/whfm_pkg.sv
src/whfm_ram.sv
src/weighted_histogram_fill_max_top.sv
src/whfm_checker.sv
test/testbench.sv
